// ----- rtl/core/slc_pkg.sv -----
// Package for the script lexer token classifier.
// Holds token/lexer types, keyword tables and shared widths.
// No dependencies.
`default_nettype none

package slc_pkg;

  // Widths and sizes
  localparam int POS_WIDTH_DEF   = 16;
  localparam int FIELD_W         = 16;
  localparam int NUM_WORDS       = 17;
  localparam int WORD_CHARS      = 10;
  localparam int QUEUE_DEPTH_DEF = 4;

  // Input command codes
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_END  = 1'b1;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_NAME = 2'd1,
    MODE_NUM  = 2'd2,
    MODE_STR  = 2'd3
  } lex_mode_t;

  typedef enum logic [2:0] {
    KIND_NAME    = 3'd0,
    KIND_KEYWORD = 3'd1,
    KIND_NUMBER  = 3'd2,
    KIND_STRING  = 3'd3,
    KIND_END     = 3'd4,
    KIND_ERROR   = 3'd5
  } token_kind_t;

  typedef struct packed {
    token_kind_t          kind;
    logic [FIELD_W-1:0]   start;
    logic [FIELD_W-1:0]   len;
    logic                 last;
  } token_t;

  // Up to two tokens produced by one input transaction
  typedef struct packed {
    logic   two;
    token_t first;
    token_t second;
  } token_pair_t;

  localparam logic [NUM_WORDS-1:0] ALL_WORDS = '1;

  // Keywords, left aligned and padded with spaces (a space never matches
  // a name character)
  localparam logic [8*WORD_CHARS-1:0] KW_TEXT [NUM_WORDS] = '{
    "if        ", "try       ", "elif      ", "else      ", "echo      ",
    "exit      ", "close     ", "raise     ", "while     ", "break     ",
    "prompt    ", "typeof    ", "return    ", "iferror   ", "continue  ",
    "function  ", "loadimport"
  };

  localparam logic [3:0] KW_LEN [NUM_WORDS] = '{
    4'd2, 4'd3, 4'd4, 4'd4, 4'd4, 4'd4, 4'd5, 4'd5, 4'd5, 4'd5,
    4'd6, 4'd6, 4'd6, 4'd7, 4'd8, 4'd8, 4'd10
  };

  // Character of keyword w at offset idx, zero past the table
  function automatic logic [7:0] kw_char(input int unsigned w, input logic [3:0] idx);
    logic [8*WORD_CHARS-1:0] txt;
    txt = KW_TEXT[w];
    if (idx >= 4'(WORD_CHARS)) return 8'h00;
    return txt[8*(WORD_CHARS-1-int'(idx)) +: 8];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/slc_if.sv -----
// Channel interfaces for the script lexer token classifier.
// Depends on nothing; field widths follow the token descriptor layout.
`default_nettype none

interface slc_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] text_byte;

  modport source (output valid, output cmd, output text_byte, input ready);
  modport sink   (input valid, input cmd, input text_byte, output ready);
endinterface

interface slc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  token_kind;
  logic [15:0] start_pos;
  logic [15:0] token_len;
  logic        last_of_run;

  modport source (output valid, output token_kind, output start_pos,
                  output token_len, output last_of_run, input ready);
  modport sink   (input valid, input token_kind, input start_pos,
                  input token_len, input last_of_run, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/slc_front.sv -----
// Front end of the lexer: holds scan state, classifies each byte and
// builds the tokens one transaction causes. Depends on slc_pkg.
`default_nettype none

module slc_front
  import slc_pkg::*;
#(
  parameter int POS_WIDTH = POS_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        fire,
  input  wire logic        cmd,
  input  wire logic [7:0]  text_byte,
  output      logic        push,
  output      token_pair_t push_data
);

  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_BQ    = 8'h60;

  typedef logic [POS_WIDTH-1:0] pos_t;

  function automatic pos_t sat_inc(input pos_t v);
    return (v == '1) ? v : v + POS_WIDTH'(1);
  endfunction

  function automatic logic [FIELD_W-1:0] sat_field(input pos_t v);
    if ((v >> FIELD_W) != '0) return '1;
    return FIELD_W'(v);
  endfunction

  lex_mode_t              mode_r, mode_nxt;
  logic [7:0]             quote_r, quote_nxt;
  logic                   point_r, point_nxt;
  pos_t                   start_r, start_nxt;
  pos_t                   len_r, len_nxt;
  pos_t                   pos_r, pos_nxt;
  logic [NUM_WORDS-1:0]   cand_r, cand_nxt;
  logic                   err_r, err_nxt;

  logic                   is_alpha, is_digit, is_space, is_quote;
  logic [3:0]             char_idx;
  logic [NUM_WORDS-1:0]   cand_cont, cand_first;
  logic                   is_kw;
  token_t                 flush_tok, end_tok, err_tok;
  token_t                 tok_a, tok_b;
  logic [1:0]             cnt;
  logic                   take_flush, take_begin;

  // Classify the incoming byte
  always_comb begin
    is_alpha = ((text_byte >= CH_LA) && (text_byte <= CH_LZ)) ||
               ((text_byte >= CH_UA) && (text_byte <= CH_UZ));
    is_digit = (text_byte >= CH_ZERO) && (text_byte <= CH_NINE);
    is_space = (text_byte == CH_SP) || (text_byte == CH_TAB) ||
               (text_byte == CH_LF) || (text_byte == CH_CR);
    is_quote = (text_byte == CH_DQ) || (text_byte == CH_SQ) || (text_byte == CH_BQ);
  end

  // Narrow the keyword candidates in parallel, one compare per word
  assign char_idx = (len_r >= POS_WIDTH'(16)) ? 4'd15 : len_r[3:0];

  always_comb begin
    for (int i = 0; i < NUM_WORDS; i++) begin
      cand_cont[i]  = cand_r[i] && (kw_char(i, char_idx) == text_byte);
      cand_first[i] = (kw_char(i, 4'd0) == text_byte);
    end
  end

  always_comb begin
    is_kw = 1'b0;
    for (int i = 0; i < NUM_WORDS; i++) begin
      if (cand_r[i] && (len_r == POS_WIDTH'(KW_LEN[i]))) is_kw = 1'b1;
    end
  end

  // Tokens that may leave in this transaction
  always_comb begin
    flush_tok = '0;
    case (mode_r)
      MODE_NAME: flush_tok.kind = is_kw ? KIND_KEYWORD : KIND_NAME;
      MODE_NUM:  flush_tok.kind = KIND_NUMBER;
      MODE_STR:  flush_tok.kind = KIND_STRING;
      default:   flush_tok.kind = KIND_NAME;
    endcase
    flush_tok.start = sat_field(start_r);
    flush_tok.len   = sat_field(len_r);

    end_tok       = '0;
    end_tok.kind  = KIND_END;
    end_tok.start = sat_field(pos_r);

    err_tok       = '0;
    err_tok.kind  = KIND_ERROR;
    err_tok.start = sat_field(pos_r);
    err_tok.len   = FIELD_W'(1);
  end

  // Next scan state and token assembly
  always_comb begin
    mode_nxt   = mode_r;
    quote_nxt  = quote_r;
    point_nxt  = point_r;
    start_nxt  = start_r;
    len_nxt    = len_r;
    pos_nxt    = pos_r;
    cand_nxt   = cand_r;
    err_nxt    = err_r;
    tok_a      = '0;
    tok_b      = '0;
    cnt        = 2'd0;
    take_flush = 1'b0;
    take_begin = 1'b0;

    if (cmd == CMD_END) begin
      if (!err_r && (mode_r != MODE_IDLE)) begin
        tok_a = flush_tok;
        tok_b = end_tok;
        cnt   = 2'd2;
      end else begin
        tok_a = end_tok;
        cnt   = 2'd1;
      end
      // Return to the reset state
      mode_nxt  = MODE_IDLE;
      quote_nxt = '0;
      point_nxt = 1'b0;
      start_nxt = '0;
      len_nxt   = '0;
      pos_nxt   = '0;
      cand_nxt  = ALL_WORDS;
      err_nxt   = 1'b0;
    end else if (!err_r) begin
      case (mode_r)
        MODE_NAME: begin
          if (is_alpha || is_digit) begin
            cand_nxt = cand_cont;
            len_nxt  = sat_inc(len_r);
          end else begin
            take_flush = 1'b1;
            take_begin = 1'b1;
          end
        end
        MODE_NUM: begin
          if (is_digit) begin
            len_nxt = sat_inc(len_r);
          end else if ((text_byte == CH_POINT) && !point_r) begin
            point_nxt = 1'b1;
            len_nxt   = sat_inc(len_r);
          end else begin
            take_flush = 1'b1;
            take_begin = 1'b1;
          end
        end
        MODE_STR: begin
          if (text_byte == quote_r) begin
            take_flush = 1'b1;
          end else begin
            len_nxt = sat_inc(len_r);
          end
        end
        default: take_begin = 1'b1;
      endcase

      if (take_flush) begin
        tok_a    = flush_tok;
        cnt      = 2'd1;
        mode_nxt = MODE_IDLE;
      end

      // Start a token on this byte, from idle or after a flush
      if (take_begin) begin
        if (is_space) begin
          mode_nxt = MODE_IDLE;
        end else if (is_alpha) begin
          mode_nxt  = MODE_NAME;
          start_nxt = pos_r;
          len_nxt   = POS_WIDTH'(1);
          cand_nxt  = cand_first;
        end else if (is_digit) begin
          mode_nxt  = MODE_NUM;
          point_nxt = 1'b0;
          start_nxt = pos_r;
          len_nxt   = POS_WIDTH'(1);
        end else if (is_quote) begin
          mode_nxt  = MODE_STR;
          quote_nxt = text_byte;
          start_nxt = sat_inc(pos_r);
          len_nxt   = '0;
        end else begin
          mode_nxt = MODE_IDLE;
          err_nxt  = 1'b1;
          if (take_flush) begin
            tok_b = err_tok;
            cnt   = 2'd2;
          end else begin
            tok_a = err_tok;
            cnt   = 2'd1;
          end
        end
      end

      if (!err_nxt) pos_nxt = sat_inc(pos_r);
    end

    // Mark the final token of the transaction
    if (cnt == 2'd2) tok_b.last = 1'b1;
    else             tok_a.last = 1'b1;
  end

  assign push             = fire && (cnt != 2'd0);
  assign push_data.two    = (cnt == 2'd2);
  assign push_data.first  = tok_a;
  assign push_data.second = tok_b;

  // Advance scan state on each accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      quote_r <= '0;
      point_r <= 1'b0;
      start_r <= '0;
      len_r   <= '0;
      pos_r   <= '0;
      cand_r  <= ALL_WORDS;
      err_r   <= 1'b0;
    end else if (fire) begin
      mode_r  <= mode_nxt;
      quote_r <= quote_nxt;
      point_r <= point_nxt;
      start_r <= start_nxt;
      len_r   <= len_nxt;
      pos_r   <= pos_nxt;
      cand_r  <= cand_nxt;
      err_r   <= err_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/slc_queue.sv -----
// Short queue of token pairs between the lexer front and back ends.
// Depends on slc_pkg.
`default_nettype none

module slc_queue
  import slc_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  input  wire token_pair_t push_data,
  input  wire logic        pop,
  output      logic        full,
  output      logic        not_empty,
  output      token_pair_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  token_pair_t         mem_r [DEPTH];
  logic [PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = mem_r[rd_ptr_r];

  // Wrap pointers and track fill level
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + CNT_W'(1);
      2'b01:   count_nxt = count_r - CNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store entries; no reset on payload
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full) else $error("queue written while full");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty) else $error("queue read while empty");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH)) else $error("queue count overflow");

endmodule

`default_nettype wire

// ----- rtl/core/slc_back.sv -----
// Back end of the lexer: takes token pairs off the queue and presents
// them one transaction at a time from an output register. Depends on slc_pkg.
`default_nettype none

module slc_back
  import slc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        q_not_empty,
  input  wire token_pair_t q_head,
  output      logic        q_pop,
  output      logic        out_valid,
  input  wire logic        out_ready,
  output      token_t      out_tok
);

  token_pair_t pair_r, pair_nxt;
  logic        valid_r, valid_nxt;
  logic        sel_r, sel_nxt;
  logic        done;

  // The pair is finished when its last token is taken
  assign done  = valid_r && out_ready && (sel_r || !pair_r.two);
  assign q_pop = q_not_empty && (!valid_r || done);

  always_comb begin
    pair_nxt  = pair_r;
    valid_nxt = valid_r;
    sel_nxt   = sel_r;
    if (valid_r && out_ready) begin
      if (!sel_r && pair_r.two) sel_nxt = 1'b1;
      else                      valid_nxt = 1'b0;
    end
    // Load the next pair from the queue
    if (q_pop) begin
      pair_nxt  = q_head;
      valid_nxt = 1'b1;
      sel_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      sel_r   <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      sel_r   <= sel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pair_r <= pair_nxt;
  end

  assign out_valid = valid_r;
  assign out_tok   = sel_r ? pair_r.second : pair_r.first;

endmodule

`default_nettype wire

// ----- rtl/core/script_lexer_token_classifier_core.sv -----
// Top level of the script lexer token classifier.
// Depends on slc_pkg, slc_if, slc_front, slc_queue and slc_back.
//
//   channel   dir   handshake      payload
//   in_chan   in    valid/ready    cmd, text_byte
//   out_chan  out   valid/ready    token_kind, start_pos, token_len, last_of_run
//
// One input transaction is taken per cycle while the token queue has room.
// A transaction that yields two tokens holds the output register until both
// have left in turn; the queue of QUEUE_DEPTH pairs absorbs such bursts.
// The first token is registered in the queue, then in the output register.
// Synchronous active-low reset returns the lexer to idle at position zero
// and empties the queue.
`default_nettype none

module script_lexer_token_classifier_core
  import slc_pkg::*;
#(
  parameter int POS_WIDTH   = POS_WIDTH_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input wire logic  clk,
  input wire logic  rst_n,
  slc_in_if.sink    in_chan,
  slc_out_if.source out_chan
);

  logic        fire;
  logic        push;
  token_pair_t push_data;
  logic        q_full;
  logic        q_not_empty;
  logic        q_pop;
  token_pair_t q_head;
  token_t      out_tok;

  // Accept while the queue has room
  assign in_chan.ready = !q_full;
  assign fire          = in_chan.valid && !q_full;

  slc_front #(
    .POS_WIDTH (POS_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .cmd       (in_chan.cmd),
    .text_byte (in_chan.text_byte),
    .push      (push),
    .push_data (push_data)
  );

  slc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  slc_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_valid   (out_chan.valid),
    .out_ready   (out_chan.ready),
    .out_tok     (out_tok)
  );

  // Drive the result payload
  assign out_chan.token_kind  = out_tok.kind;
  assign out_chan.start_pos   = out_tok.start;
  assign out_chan.token_len   = out_tok.len;
  assign out_chan.last_of_run = out_tok.last;

endmodule

`default_nettype wire
